[rtl/sld_pkg.sv]
// Shared types and constants for the start-of-frame, length and CRC-16 deframer.
// No dependencies; every other file of the block imports this package.
package sld_pkg;

  localparam int BUFFER_BYTES_DEF = 128;
  localparam int HDR_BYTES        = 10;
  localparam int CRC_BYTES        = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  localparam logic [7:0] SOF0_RESET  = 8'hAA;
  localparam logic [7:0] SOF1_RESET  = 8'h55;
  localparam logic [7:0] TRACE_RESET = 8'h00;

  typedef enum logic [1:0] {
    CFG_SOF0  = 2'd0,
    CFG_SOF1  = 2'd1,
    CFG_TRACE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CRC_OK   = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_TOO_LONG = 2'd2
  } frame_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t    item_kind;
    logic [7:0]    payload_byte;
    frame_status_t frame_status;
    logic [7:0]    frame_seq;
    logic [31:0]   frame_timestamp;
    logic [7:0]    frame_type;
    logic          is_trace;
    logic [15:0]   payload_length;
    logic          last_of_frame;
  } sld_result_t;

endpackage

[rtl/sof_length_crc16_deframer_core.sv]
// Deframer top level: input register, frame parser and output register.
// Throughput: one byte per cycle; the only limit is the output register,
// which refills in the cycle it is emptied.
// Reset (rst_n low, synchronous) clears both registers' valid bits, puts the
// parser back to hunting with CRC 0xFFFF and restores the register defaults.
module sof_length_crc16_deframer_core
  import sld_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [9:8] frame_status, [17:10] frame_seq,
  // [49:18] frame_timestamp, [57:50] frame_type, [58] is_trace,
  // [74:59] payload_length, [79:75] zero
  output logic [79:0] out_tdata,
  output logic [0:0]  out_tuser,  // [0] item_kind
  output logic        out_tlast,  // last_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic        in_v_r, in_v_nxt;
  logic [7:0]  in_byte_r, in_byte_nxt;
  logic        out_v_r, out_v_nxt;
  sld_result_t out_r, out_nxt;
  logic [7:0]  sof0_r, sof0_nxt;
  logic [7:0]  sof1_r, sof1_nxt;
  logic [7:0]  trace_r, trace_nxt;
  logic        go;
  logic        res_valid;
  sld_result_t res;

  // The held item is processed whenever the output register is free or
  // being emptied in this cycle.
  assign go        = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || go;
  assign cfg_ready = 1'b1;

  sld_parser #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (go),
    .rx_byte    (in_byte_r),
    .sof0       (sof0_r),
    .sof1       (sof1_r),
    .trace_code (trace_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_comb begin
    in_v_nxt    = in_v_r;
    in_byte_nxt = in_byte_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt    = 1'b1;
      in_byte_nxt = in_tdata;
    end else if (go) begin
      in_v_nxt = 1'b0;
    end

    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (go) begin
      out_v_nxt = res_valid;
      out_nxt   = res;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end

    sof0_nxt  = sof0_r;
    sof1_nxt  = sof1_r;
    trace_nxt = trace_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SOF0:  sof0_nxt  = cfg_data;
        CFG_SOF1:  sof1_nxt  = cfg_data;
        CFG_TRACE: trace_nxt = cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      sof0_r  <= SOF0_RESET;
      sof1_r  <= SOF1_RESET;
      trace_r <= TRACE_RESET;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      sof0_r  <= sof0_nxt;
      sof1_r  <= sof1_nxt;
      trace_r <= trace_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
    out_r     <= out_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.item_kind;
  assign out_tlast  = out_r.last_of_frame;
  assign out_tdata  = {5'b00000, out_r.payload_length, out_r.is_trace, out_r.frame_type,
                       out_r.frame_timestamp, out_r.frame_seq, out_r.frame_status,
                       out_r.payload_byte};

endmodule

[rtl/sld_crc_byte.sv]
// Byte-wide CRC-16/CCITT-FALSE update, MSB first, unrolled over eight bits.
// Depends on sld_pkg for the polynomial.
module sld_crc_byte
  import sld_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

[rtl/sld_parser.sv]
// Frame parser: byte position counter, header holds, CRC accumulator and
// result formation for one byte per step. Depends on sld_pkg and sld_crc_byte.
module sld_parser
  import sld_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  sof0,
  input  logic [7:0]  sof1,
  input  logic [7:0]  trace_code,
  output logic        res_valid,
  output sld_result_t res
);

  // Every position inside a frame that fits stays below BUFFER_BYTES.
  localparam int POS_W = $clog2(BUFFER_BYTES);

  localparam logic [POS_W-1:0] P_HUNT   = POS_W'(0);
  localparam logic [POS_W-1:0] P_SOF1   = POS_W'(1);
  localparam logic [POS_W-1:0] P_SEQ    = POS_W'(2);
  localparam logic [POS_W-1:0] P_TS_END = POS_W'(6);
  localparam logic [POS_W-1:0] P_TYPE   = POS_W'(7);
  localparam logic [POS_W-1:0] P_LEN_LO = POS_W'(8);
  localparam logic [POS_W-1:0] P_HDR    = POS_W'(HDR_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt, crc_upd;
  logic [7:0]       seq_r, seq_nxt;
  logic [31:0]      ts_r, ts_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [16:0]      pay_end;
  logic [16:0]      frame_total;
  logic [1:0]       ts_lane;

  sld_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign pay_end     = 17'(HDR_BYTES) + {1'b0, len_r};
  assign frame_total = 17'(HDR_BYTES + CRC_BYTES) + {1'b0, rx_byte, len_r[7:0]};
  assign ts_lane     = 2'(pos_r - POS_W'(3));

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    seq_nxt    = seq_r;
    ts_nxt     = ts_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    crc_lo_nxt = crc_lo_r;
    res_valid  = 1'b0;
    res        = '0;

    if (step) begin
      if (pos_r == P_HUNT) begin
        if (rx_byte == sof0) begin
          pos_nxt = P_SOF1;
        end
      end else if (pos_r == P_SOF1) begin
        // A wrong second byte is not taken as a new first byte.
        if (rx_byte == sof1) begin
          pos_nxt = P_SEQ;
          crc_nxt = CRC_INIT;
        end else begin
          pos_nxt = P_HUNT;
        end
      end else if (pos_r < P_HDR) begin
        crc_nxt = crc_upd;
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r == P_SEQ) begin
          seq_nxt = rx_byte;
        end else if (pos_r <= P_TS_END) begin
          case (ts_lane)
            2'd0:    ts_nxt[7:0]   = rx_byte;
            2'd1:    ts_nxt[15:8]  = rx_byte;
            2'd2:    ts_nxt[23:16] = rx_byte;
            default: ts_nxt[31:24] = rx_byte;
          endcase
        end else if (pos_r == P_TYPE) begin
          type_nxt = rx_byte;
        end else if (pos_r == P_LEN_LO) begin
          len_nxt[7:0] = rx_byte;
        end else begin
          len_nxt[15:8] = rx_byte;
          if (frame_total > 17'(BUFFER_BYTES)) begin
            pos_nxt   = P_HUNT;
            res_valid = 1'b1;
            res.item_kind       = KIND_SUMMARY;
            res.frame_status    = ST_TOO_LONG;
            res.frame_seq       = seq_r;
            res.frame_timestamp = ts_r;
            res.frame_type      = type_r;
            res.is_trace        = (type_r == trace_code);
            res.payload_length  = len_nxt;
            res.last_of_frame   = 1'b1;
          end
        end
      end else if (17'(pos_r) < pay_end) begin
        crc_nxt   = crc_upd;
        pos_nxt   = pos_r + POS_W'(1);
        res_valid = 1'b1;
        res.item_kind    = KIND_PAYLOAD;
        res.payload_byte = rx_byte;
      end else if (17'(pos_r) == pay_end) begin
        crc_lo_nxt = rx_byte;
        pos_nxt    = pos_r + POS_W'(1);
      end else begin
        pos_nxt   = P_HUNT;
        res_valid = 1'b1;
        res.item_kind       = KIND_SUMMARY;
        res.frame_status    = ({rx_byte, crc_lo_r} == crc_r) ? ST_CRC_OK : ST_CRC_BAD;
        res.frame_seq       = seq_r;
        res.frame_timestamp = ts_r;
        res.frame_type      = type_r;
        res.is_trace        = (type_r == trace_code);
        res.payload_length  = len_r;
        res.last_of_frame   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= P_HUNT;
      crc_r    <= CRC_INIT;
      seq_r    <= 8'h00;
      ts_r     <= 32'h0;
      type_r   <= 8'h00;
      len_r    <= 16'h0;
      crc_lo_r <= 8'h00;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      seq_r    <= seq_nxt;
      ts_r     <= ts_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

[dv/sof_length_crc16_deframer_core_tb.sv]
// Self-checking testbench for the start-of-frame, length and CRC-16 deframer core.
// Drives bytes and register writes, predicts payload and frame-end items in a local model.
// Depends on sld_pkg and the sof_length_crc16_deframer_core RTL only.
`timescale 1ns / 1ps

module sof_length_crc16_deframer_core_tb;
  import sld_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;  // no register behind this index
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_PRINTS = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  // [7:0] payload_byte, [9:8] frame_status, [17:10] frame_seq,
  // [49:18] frame_timestamp, [57:50] frame_type, [58] is_trace,
  // [74:59] payload_length, [79:75] zero
  logic [79:0] out_tdata;
  logic [0:0]  out_tuser;   // [0] item_kind
  logic        out_tlast;   // last_of_frame
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  sof_length_crc16_deframer_core #(
    .BUFFER_BYTES(BUFFER_BYTES_DEF)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Local copy of the parser state and the registers.
  int          parse_pos;
  logic [15:0] crc_run;
  logic [7:0]  seq_seen;
  logic [31:0] stamp_seen;
  logic [7:0]  type_seen;
  logic [15:0] len_seen;
  logic [7:0]  crc_low_seen;
  logic [7:0]  reg_sof0;
  logic [7:0]  reg_sof1;
  logic [7:0]  reg_trace;

  sld_result_t pending_results[$];

  int mismatch_count;
  int items_compared;
  int frame_bytes;
  int frames_sent;
  int frames_too_long;
  int frames_bad_crc;
  int noise_bytes;
  int settings_used;
  int calm_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
    c = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 16'h0) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

  function automatic sld_result_t frame_end(frame_status_t st);
    sld_result_t r;
    r = '0;
    r.item_kind       = KIND_SUMMARY;
    r.frame_status    = st;
    r.frame_seq       = seq_seen;
    r.frame_timestamp = stamp_seen;
    r.frame_type      = type_seen;
    r.is_trace        = (type_seen == reg_trace);
    r.payload_length  = len_seen;
    r.last_of_frame   = 1'b1;
    return r;
  endfunction

  task automatic reset_predictor();
    parse_pos    = 0;
    crc_run      = CRC_INIT;
    seq_seen     = '0;
    stamp_seen   = '0;
    type_seen    = '0;
    len_seen     = '0;
    crc_low_seen = '0;
    reg_sof0     = SOF0_RESET;
    reg_sof1     = SOF1_RESET;
    reg_trace    = TRACE_RESET;
  endtask

  // Advances the local parser by one accepted byte and queues what it emits.
  task automatic deframe_byte(input logic [7:0] b);
    sld_result_t r;
    logic [15:0] rx_crc;
    r = '0;
    if (parse_pos == 0) begin
      if (b == reg_sof0) parse_pos = 1;
    end else if (parse_pos == 1) begin
      // A wrong second byte is dropped, not tried again as a first byte.
      if (b == reg_sof1) begin
        parse_pos = 2;
        crc_run = CRC_INIT;
      end else begin
        parse_pos = 0;
      end
    end else if (parse_pos < HDR_BYTES) begin
      crc_run = crc_next(crc_run, b);
      if (parse_pos == 2) seq_seen = b;
      else if (parse_pos <= 6) stamp_seen[8*(parse_pos-3) +: 8] = b;
      else if (parse_pos == 7) type_seen = b;
      else if (parse_pos == 8) len_seen[7:0] = b;
      else len_seen[15:8] = b;
      if (parse_pos == HDR_BYTES - 1 &&
          HDR_BYTES + int'(len_seen) + CRC_BYTES > BUFFER_BYTES_DEF) begin
        pending_results.push_back(frame_end(ST_TOO_LONG));
        parse_pos = 0;
      end else begin
        parse_pos++;
      end
    end else if (parse_pos < HDR_BYTES + int'(len_seen)) begin
      crc_run = crc_next(crc_run, b);
      parse_pos++;
      r.item_kind = KIND_PAYLOAD;
      r.payload_byte = b;
      pending_results.push_back(r);
    end else if (parse_pos == HDR_BYTES + int'(len_seen)) begin
      crc_low_seen = b;
      parse_pos++;
    end else begin
      rx_crc = {b, crc_low_seen};
      pending_results.push_back(frame_end((rx_crc == crc_run) ? ST_CRC_OK : ST_CRC_BAD));
      parse_pos = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t: %s differs, got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_result();
    sld_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("item with nothing pending, kind", {31'b0, out_tuser[0]}, '0);
    end else begin
      want = pending_results.pop_front();
      items_compared++;
      if (out_tuser[0] !== want.item_kind)
        report_mismatch("item_kind", {31'b0, out_tuser[0]}, {31'b0, want.item_kind});
      if (out_tdata[7:0] !== want.payload_byte)
        report_mismatch("payload_byte", {24'b0, out_tdata[7:0]}, {24'b0, want.payload_byte});
      if (out_tdata[9:8] !== want.frame_status)
        report_mismatch("frame_status", {30'b0, out_tdata[9:8]}, {30'b0, want.frame_status});
      if (out_tdata[17:10] !== want.frame_seq)
        report_mismatch("frame_seq", {24'b0, out_tdata[17:10]}, {24'b0, want.frame_seq});
      if (out_tdata[49:18] !== want.frame_timestamp)
        report_mismatch("frame_timestamp", out_tdata[49:18], want.frame_timestamp);
      if (out_tdata[57:50] !== want.frame_type)
        report_mismatch("frame_type", {24'b0, out_tdata[57:50]}, {24'b0, want.frame_type});
      if (out_tdata[58] !== want.is_trace)
        report_mismatch("is_trace", {31'b0, out_tdata[58]}, {31'b0, want.is_trace});
      if (out_tdata[74:59] !== want.payload_length)
        report_mismatch("payload_length", {16'b0, out_tdata[74:59]},
                        {16'b0, want.payload_length});
      if (out_tdata[79:75] !== 5'b0)
        report_mismatch("padding", {27'b0, out_tdata[79:75]}, '0);
      if (out_tlast !== want.last_of_frame)
        report_mismatch("last_of_frame", {31'b0, out_tlast}, {31'b0, want.last_of_frame});
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
  end

  // Output side: ready runs broken by stalls, now and then a long stretch with none.
  initial begin : sink_pacing
    int r;
    int run_len;
    int hold_len;
    forever begin
      r = $urandom_range(99, 0);
      run_len = (r < 5) ? $urandom_range(300, 100) : $urandom_range(12, 1);
      r = $urandom_range(99, 0);
      if (r < 30) hold_len = 0;
      else if (r < 90) hold_len = $urandom_range(3, 1);
      else hold_len = $urandom_range(40, 10);
      out_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 3) begin
      calm_left = $urandom_range(150, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Valid stays high from one item to the next unless a gap is inserted.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!in_tvalid) in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every pending item has come out and the pipeline has emptied.
  task automatic settle();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] v0, input logic [7:0] v1,
                              input logic [7:0] v2);
    logic [1:0] idx[4];
    logic [7:0] val[4];
    idx = '{CFG_UNUSED, CFG_SOF0, CFG_SOF1, CFG_TRACE};
    val = '{8'($urandom), v0, v1, v2};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_SOF0:  reg_sof0  = val[i];
        CFG_SOF1:  reg_sof1  = val[i];
        CFG_TRACE: reg_trace = val[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Sends a whole frame; an oversized one stops after its length field.
  task automatic send_frame(input logic [7:0] seq, input logic [31:0] stamp,
                            input logic [7:0] typ, input logic [15:0] len,
                            input bit bad_crc);
    logic [7:0]  hdr[8];
    logic [15:0] c;
    logic [7:0]  pb;
    hdr = '{seq, stamp[7:0], stamp[15:8], stamp[23:16], stamp[31:24], typ,
            len[7:0], len[15:8]};
    c = CRC_INIT;
    frames_sent++;
    send_byte(reg_sof0);
    send_byte(reg_sof1);
    for (int i = 0; i < 8; i++) begin
      c = crc_next(c, hdr[i]);
      send_byte(hdr[i]);
    end
    frame_bytes += 10;
    if (HDR_BYTES + int'(len) + CRC_BYTES > BUFFER_BYTES_DEF) begin
      frames_too_long++;
    end else begin
      for (int i = 0; i < int'(len); i++) begin
        pb = 8'($urandom);
        c = crc_next(c, pb);
        send_byte(pb);
      end
      if (bad_crc) begin
        c = c ^ (16'h1 << $urandom_range(15, 0));
        frames_bad_crc++;
      end
      send_byte(c[7:0]);
      send_byte(c[15:8]);
      frame_bytes += int'(len) + 2;
    end
  endtask

  // Random bytes and false starts; leaves the parser hunting where it can.
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99, 0) < 30) begin
        send_byte(reg_sof0);
        send_byte(reg_sof1 ^ 8'($urandom_range(255, 1)));
        noise_bytes += 2;
      end else begin
        send_byte(8'($urandom));
        noise_bytes++;
      end
    end
    while (parse_pos == 1) begin
      send_byte(reg_sof1 ^ 8'h01);
      noise_bytes++;
    end
  endtask

  task automatic test_hunt_restart();
    // The repeated first byte must not count as a new first byte.
    send_byte(reg_sof0);
    send_byte(reg_sof0);
    send_byte(reg_sof1);
    noise_bytes += 3;
  endtask

  task automatic test_oversize_header();
    // Largest length field: no 16-bit wrap of the total may let it through.
    send_frame(8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 1'b0);
  endtask

  task automatic test_config_mid_frame();
    logic [7:0]  hdr[8];
    logic [15:0] c;
    // Empty frame with all-zero fields; the trace code moves while it is parsed.
    hdr = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    c = CRC_INIT;
    frames_sent++;
    send_byte(reg_sof0);
    send_byte(reg_sof1);
    for (int i = 0; i < 6; i++) begin
      c = crc_next(c, hdr[i]);
      send_byte(hdr[i]);
    end
    settle();
    program_regs(reg_sof0, reg_sof1, 8'h3C);
    settings_used++;
    for (int i = 6; i < 8; i++) begin
      c = crc_next(c, hdr[i]);
      send_byte(hdr[i]);
    end
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    frame_bytes += 12;
  endtask

  task automatic test_random_frames(input logic [7:0] sof0, input logic [7:0] sof1,
                                    input logic [7:0] trace, input int budget);
    int          stop_at;
    int          r;
    logic [15:0] len;
    logic [7:0]  typ;
    logic [31:0] stamp;
    settle();
    program_regs(sof0, sof1, trace);
    settings_used++;
    stop_at = frame_bytes + budget;
    while (frame_bytes < stop_at) begin
      if ($urandom_range(99, 0) < 12) begin
        send_noise($urandom_range(6, 1));
      end else begin
        r = $urandom_range(99, 0);
        if (r < 60) len = 16'($urandom_range(6, 0));
        else if (r < 80) len = 16'($urandom_range(30, 7));
        else if (r < 88) len = 16'($urandom_range(115, 100));
        else if (r < 92) len = 16'(BUFFER_BYTES_DEF - HDR_BYTES - CRC_BYTES);
        else if (r < 95) len = 16'(BUFFER_BYTES_DEF - HDR_BYTES - CRC_BYTES + 1);
        else if (r < 98) len = 16'($urandom_range(65535, 118));
        else len = 16'hFFFF;
        r = $urandom_range(99, 0);
        if (r < 10) stamp = 32'h0;
        else if (r < 20) stamp = 32'hFFFF_FFFF;
        else stamp = $urandom;
        typ = ($urandom_range(2, 0) == 0) ? reg_trace : 8'($urandom);
        send_frame(8'($urandom), stamp, typ, len, $urandom_range(4, 0) == 0);
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SOF0;
    cfg_data  <= '0;
    mismatch_count  = 0;
    items_compared  = 0;
    frame_bytes     = 0;
    frames_sent     = 0;
    frames_too_long = 0;
    frames_bad_crc  = 0;
    noise_bytes     = 0;
    settings_used   = 1;
    calm_left       = 0;
    reset_predictor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_hunt_restart();
    test_oversize_header();
    test_config_mid_frame();
    test_random_frames(8'h00, 8'hFF, 8'hFF, 190);
    test_random_frames(8'hFF, 8'h00, 8'h00, 190);
    test_random_frames(SOF0_RESET, SOF1_RESET, 8'($urandom), 190);
    test_random_frames(8'($urandom), 8'($urandom), 8'($urandom), 190);
    settle();

    $display("Sent %0d frames (%0d oversized, %0d with a corrupted check) and %0d noise bytes.",
             frames_sent, frames_too_long, frames_bad_crc, noise_bytes);
    $display("Compared %0d result items across %0d register settings.",
             items_compared, settings_used);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run stopped by the time limit with %0d items still pending.",
             pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
